/* src/pst_pkg.sv */
// Shared types and constants for the property slot table.
// Used by the controller, the datapath, the top level and the checker.
package pst_pkg;

  localparam int NUM_SLOTS = 64;
  localparam int SLOT_W    = 6;
  localparam int CNT_W     = 7;
  localparam int KEY_W     = 63;
  localparam int ID_W      = 62;
  localparam int ATTR_W    = 8;
  localparam logic [CNT_W-1:0] CMP_MIN_RESET = 7'd32;

  typedef enum logic [2:0] {
    OP_ADD     = 3'd0,
    OP_LOOKUP  = 3'd1,
    OP_SETATTR = 3'd2,
    OP_REMOVE  = 3'd3,
    OP_COMPACT = 3'd4,
    OP_READ    = 3'd5
  } op_t;

  typedef enum logic [1:0] {
    ST_OK    = 2'd0,
    ST_NOKEY = 2'd1,
    ST_FULL  = 2'd2,
    ST_BAD   = 2'd3
  } status_t;

  typedef enum logic [3:0] {
    S_IDLE, S_DISPATCH, S_SCAN, S_SCAN_CHK, S_TRIM,
    S_CMP_CHK, S_CMP_WR, S_READ_OUT, S_DONE
  } state_t;

  typedef enum logic [4:0] {
    A_NONE, A_ACCEPT, A_SET_NOKEY, A_RD_I, A_MATCH, A_NEXT_I, A_MISS,
    A_APPEND, A_FULL, A_BAD, A_REMOVE, A_TRIM, A_CMP_SKIP, A_CMP_RD,
    A_CMP_WR, A_CMP_END, A_RD_SIN, A_READ_OUT, A_EMIT
  } act_t;

  typedef struct packed {
    act_t act;
  } ctrl_cmd_t;

  typedef struct packed {
    logic [2:0] op;
    logic       key_zero;
    logic       i_done;
    logic       match;
    logic       bad_slot;
    logic       slot_full;
    logic       trim_more;
    logic       del_i;
    logic       dc_zero;
    logic       out_free;
  } dp_sts_t;

endpackage

/* src/pst_ctrl.sv */
// Controller state machine for the property slot table.
// Depends on pst_pkg; drives one datapath action per cycle.
module pst_ctrl (
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  input  pst_pkg::dp_sts_t   sts,
  output pst_pkg::ctrl_cmd_t cmd,
  output logic               busy
);
  import pst_pkg::*;

  state_t state, state_next;
  logic   key_op;

  assign key_op = (sts.op == OP_ADD) || (sts.op == OP_LOOKUP) || (sts.op == OP_SETATTR);

  // state register
  always_ff @(posedge clk) begin
    if (rst) state <= S_IDLE;
    else     state <= state_next;
  end

  // next state
  always_comb begin
    state_next = state;
    unique case (state)
      S_IDLE:     if (in_valid) state_next = S_DISPATCH;
      S_DISPATCH: begin
        if (key_op) state_next = sts.key_zero ? S_DONE : S_SCAN;
        else if (sts.op == OP_REMOVE) state_next = sts.bad_slot ? S_DONE : S_TRIM;
        else if (sts.op == OP_COMPACT) state_next = sts.dc_zero ? S_DONE : S_CMP_CHK;
        else if (sts.op == OP_READ) state_next = sts.bad_slot ? S_DONE : S_READ_OUT;
        else state_next = S_DONE;
      end
      S_SCAN:     state_next = sts.i_done ? S_DONE : S_SCAN_CHK;
      S_SCAN_CHK: state_next = sts.match ? S_DONE : S_SCAN;
      S_TRIM:     if (!sts.trim_more) state_next = S_DONE;
      S_CMP_CHK: begin
        if (sts.i_done) state_next = S_DONE;
        else if (!sts.del_i) state_next = S_CMP_WR;
      end
      S_CMP_WR:   state_next = S_CMP_CHK;
      S_READ_OUT: state_next = S_DONE;
      S_DONE:     if (sts.out_free) state_next = S_IDLE;
      default:    state_next = S_IDLE;
    endcase
  end

  // datapath command
  always_comb begin
    cmd.act = A_NONE;
    unique case (state)
      S_IDLE:     if (in_valid) cmd.act = A_ACCEPT;
      S_DISPATCH: begin
        if (key_op) cmd.act = sts.key_zero ? A_SET_NOKEY : A_NONE;
        else if (sts.op == OP_REMOVE) cmd.act = sts.bad_slot ? A_BAD : A_REMOVE;
        else if (sts.op == OP_READ) cmd.act = sts.bad_slot ? A_BAD : A_RD_SIN;
        else cmd.act = A_NONE;
      end
      S_SCAN: begin
        if (!sts.i_done) cmd.act = A_RD_I;
        else if (sts.op != OP_ADD) cmd.act = A_MISS;
        else cmd.act = sts.slot_full ? A_FULL : A_APPEND;
      end
      S_SCAN_CHK: cmd.act = sts.match ? A_MATCH : A_NEXT_I;
      S_TRIM:     if (sts.trim_more) cmd.act = A_TRIM;
      S_CMP_CHK: begin
        if (sts.i_done) cmd.act = A_CMP_END;
        else cmd.act = sts.del_i ? A_CMP_SKIP : A_CMP_RD;
      end
      S_CMP_WR:   cmd.act = A_CMP_WR;
      S_READ_OUT: cmd.act = A_READ_OUT;
      S_DONE:     if (sts.out_free) cmd.act = A_EMIT;
      default:    cmd.act = A_NONE;
    endcase
  end

  assign busy = (state != S_IDLE);

endmodule

/* src/pst_dp.sv */
// Datapath of the property slot table: slot memory, deleted bits, counters,
// result and output registers. Depends on pst_pkg; steered by pst_ctrl.
module pst_dp (
  input  logic                     clk,
  input  logic                     rst,
  input  pst_pkg::ctrl_cmd_t       cmd,
  output pst_pkg::dp_sts_t         sts,
  input  logic [2:0]               op,
  input  logic [pst_pkg::ID_W-1:0] key_id,
  input  logic                     key_is_symbol,
  input  logic [7:0]               attrs,
  input  logic [5:0]               slot_in,
  input  logic                     cfg_valid,
  input  logic [6:0]               cfg_data,
  input  logic                     out_stall,
  output logic                     out_valid,
  output logic [1:0]               status,
  output logic [5:0]               slot_out,
  output logic                     invalidate,
  output logic [6:0]               live_count,
  output logic [6:0]               deleted_total,
  output logic                     should_compact,
  output logic [pst_pkg::ID_W-1:0] key_id_out,
  output logic                     key_is_symbol_out,
  output logic [7:0]               attrs_out
);
  import pst_pkg::*;

  logic [KEY_W-1:0]  mem_key [NUM_SLOTS];
  logic [ATTR_W-1:0] mem_attr [NUM_SLOTS];
  logic [KEY_W-1:0]  rkey;
  logic [ATTR_W-1:0] rattr;
  logic [NUM_SLOTS-1:0] del_bits;

  logic [2:0]        op_r;
  logic [KEY_W-1:0]  key_r;
  logic [ATTR_W-1:0] attrs_r;
  logic [SLOT_W-1:0] sin_r;
  logic [CNT_W-1:0]  sc, dc, cmp_min, idx, dst, sc_m1;

  logic [1:0]        res_status;
  logic [SLOT_W-1:0] res_slot;
  logic              res_inval;
  logic [ATTR_W-1:0] res_attr;
  logic [KEY_W-1:0]  res_key;

  logic              key_we, attr_we;
  logic [SLOT_W-1:0] wr_addr, rd_addr;
  logic [KEY_W-1:0]  key_wd;
  logic [ATTR_W-1:0] attr_wd;
  logic              out_free;

  assign sc_m1    = sc - 7'd1;
  assign out_free = !out_valid || !out_stall;

  // status toward the controller
  always_comb begin
    sts.op        = op_r;
    sts.key_zero  = (key_r == '0);
    sts.i_done    = (idx == sc);
    sts.match     = (rkey == key_r) && !del_bits[idx[SLOT_W-1:0]];
    sts.bad_slot  = ({1'b0, sin_r} >= sc) || del_bits[sin_r];
    sts.slot_full = (sc >= CNT_W'(NUM_SLOTS));
    sts.trim_more = (sc != '0) && del_bits[sc_m1[SLOT_W-1:0]];
    sts.del_i     = del_bits[idx[SLOT_W-1:0]];
    sts.dc_zero   = (dc == '0);
    sts.out_free  = out_free;
  end

  // memory port selection
  always_comb begin
    key_we  = 1'b0;
    attr_we = 1'b0;
    wr_addr = idx[SLOT_W-1:0];
    key_wd  = key_r;
    attr_wd = attrs_r;
    rd_addr = (cmd.act == A_RD_SIN) ? sin_r : idx[SLOT_W-1:0];
    unique case (cmd.act)
      A_MATCH: attr_we = (op_r == OP_SETATTR) || (op_r == OP_ADD);
      A_APPEND: begin
        key_we  = 1'b1;
        attr_we = 1'b1;
        wr_addr = sc[SLOT_W-1:0];
      end
      A_REMOVE: begin
        key_we  = 1'b1;
        attr_we = 1'b1;
        wr_addr = sin_r;
        key_wd  = '0;
        attr_wd = '0;
      end
      A_CMP_WR: begin
        key_we  = 1'b1;
        attr_we = 1'b1;
        wr_addr = dst[SLOT_W-1:0];
        key_wd  = rkey;
        attr_wd = rattr;
      end
      default: ;
    endcase
  end

  // slot memory, registered read
  always_ff @(posedge clk) begin
    if (key_we)  mem_key[wr_addr]  <= key_wd;
    if (attr_we) mem_attr[wr_addr] <= attr_wd;
    rkey  <= mem_key[rd_addr];
    rattr <= mem_attr[rd_addr];
  end

  // counters, deleted bits, config, output valid
  always_ff @(posedge clk) begin
    if (rst) begin
      sc        <= '0;
      dc        <= '0;
      cmp_min   <= CMP_MIN_RESET;
      del_bits  <= '0;
      idx       <= '0;
      dst       <= '0;
      out_valid <= 1'b0;
    end else begin
      if (cfg_valid) cmp_min <= cfg_data;
      if (out_valid && !out_stall && cmd.act != A_EMIT) out_valid <= 1'b0;
      unique case (cmd.act)
        A_ACCEPT: begin
          idx <= '0;
          dst <= '0;
        end
        A_NEXT_I, A_CMP_SKIP: idx <= idx + 7'd1;
        A_APPEND: begin
          del_bits[sc[SLOT_W-1:0]] <= 1'b0;
          sc <= sc + 7'd1;
        end
        A_REMOVE: begin
          del_bits[sin_r] <= 1'b1;
          dc <= dc + 7'd1;
        end
        A_TRIM: begin
          sc <= sc_m1;
          dc <= dc - 7'd1;
        end
        A_CMP_WR: begin
          del_bits[dst[SLOT_W-1:0]] <= 1'b0;
          dst <= dst + 7'd1;
          idx <= idx + 7'd1;
        end
        // bits at and above the new count are never read before an append clears them
        A_CMP_END: begin
          sc <= dst;
          dc <= '0;
        end
        A_EMIT: out_valid <= 1'b1;
        default: ;
      endcase
    end
  end

  // latched item, result and output payload
  always_ff @(posedge clk) begin
    unique case (cmd.act)
      A_ACCEPT: begin
        op_r       <= op;
        key_r      <= {key_id, key_is_symbol};
        attrs_r    <= attrs;
        sin_r      <= slot_in;
        res_status <= ST_OK;
        res_slot   <= '0;
        res_inval  <= 1'b0;
        res_attr   <= '0;
        res_key    <= '0;
      end
      A_SET_NOKEY, A_MISS: res_status <= ST_NOKEY;
      A_FULL:  res_status <= ST_FULL;
      A_BAD:   res_status <= ST_BAD;
      A_MATCH: begin
        res_slot <= idx[SLOT_W-1:0];
        if (op_r == OP_LOOKUP) begin
          res_attr <= rattr;
        end else begin
          res_attr  <= attrs_r;
          res_inval <= (op_r == OP_SETATTR) || (rattr != attrs_r);
        end
      end
      A_APPEND: begin
        res_slot <= sc[SLOT_W-1:0];
        res_attr <= attrs_r;
      end
      A_REMOVE: res_inval <= 1'b1;
      A_READ_OUT: begin
        res_key  <= rkey;
        res_attr <= rattr;
      end
      A_EMIT: begin
        status            <= res_status;
        slot_out          <= res_slot;
        invalidate        <= res_inval;
        live_count        <= sc;
        deleted_total     <= dc;
        should_compact    <= (dc >= cmp_min) && (dc >= (sc - dc));
        key_id_out        <= res_key[KEY_W-1:1];
        key_is_symbol_out <= res_key[0];
        attrs_out         <= res_attr;
      end
      default: ;
    endcase
  end

endmodule

/* src/property_slot_hash_table.sv */
// Top level of the property slot table: joins controller and datapath.
// Depends on pst_pkg, pst_ctrl and pst_dp.
//
//   channel | handshake              | payload
//   in      | in_valid / in_stall    | op, key_id, key_is_symbol, attrs, slot_in
//   out     | out_valid / out_stall  | status .. attrs_out
//   cfg     | cfg_valid / cfg_ready  | cfg_data (compact_min_deleted)
//
// One item at a time. Add, lookup and set attributes scan the slot memory
// slot by slot, reading and then checking each slot. Remove trims trailing
// deleted slots; compact packs live slots down; read fetches one slot.
// The result register frees the input side while a result waits on out_stall.
// Reset is synchronous and needs no clearing pass.
module property_slot_hash_table (
  input  logic                     clk,
  input  logic                     rst,
  input  logic                     in_valid,
  output logic                     in_stall,
  input  logic [2:0]               op,
  input  logic [pst_pkg::ID_W-1:0] key_id,
  input  logic                     key_is_symbol,
  input  logic [7:0]               attrs,
  input  logic [5:0]               slot_in,
  output logic                     out_valid,
  input  logic                     out_stall,
  output logic [1:0]               status,
  output logic [5:0]               slot_out,
  output logic                     invalidate,
  output logic [6:0]               live_count,
  output logic [6:0]               deleted_total,
  output logic                     should_compact,
  output logic [pst_pkg::ID_W-1:0] key_id_out,
  output logic                     key_is_symbol_out,
  output logic [7:0]               attrs_out,
  input  logic                     cfg_valid,
  output logic                     cfg_ready,
  input  logic [6:0]               cfg_data
);
  import pst_pkg::*;

  ctrl_cmd_t cmd;
  dp_sts_t   sts;
  logic      busy;

  // take config any cycle; hold input off while busy
  assign cfg_ready = 1'b1;
  assign in_stall  = busy;

  pst_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .sts      (sts),
    .cmd      (cmd),
    .busy     (busy)
  );

  pst_dp u_dp (
    .clk               (clk),
    .rst               (rst),
    .cmd               (cmd),
    .sts               (sts),
    .op                (op),
    .key_id            (key_id),
    .key_is_symbol     (key_is_symbol),
    .attrs             (attrs),
    .slot_in           (slot_in),
    .cfg_valid         (cfg_valid && cfg_ready),
    .cfg_data          (cfg_data),
    .out_stall         (out_stall),
    .out_valid         (out_valid),
    .status            (status),
    .slot_out          (slot_out),
    .invalidate        (invalidate),
    .live_count        (live_count),
    .deleted_total     (deleted_total),
    .should_compact    (should_compact),
    .key_id_out        (key_id_out),
    .key_is_symbol_out (key_is_symbol_out),
    .attrs_out         (attrs_out)
  );

endmodule

/* src/pst_checker.sv */
// Port-level checks for the property slot table, bound to the top level.
// Depends on pst_pkg.
module pst_checker (
  input logic       clk,
  input logic       rst,
  input logic       in_valid,
  input logic       in_stall,
  input logic       out_valid,
  input logic       out_stall,
  input logic [1:0] status,
  input logic       invalidate,
  input logic [6:0] live_count,
  input logic [6:0] deleted_total
);
  import pst_pkg::*;

  // a waiting result stays up
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_stall |=> out_valid) else $error("result dropped");

  // deleted slots lie below the count
  a_del_le_live: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> deleted_total <= live_count) else $error("deleted above count");

  // invalidate only on success
  a_inval_ok: assert property (@(posedge clk) disable iff (rst)
    out_valid && invalidate |-> status == ST_OK) else $error("invalidate on failure");

  // one item at a time: busy right after a transfer
  a_busy_after: assert property (@(posedge clk) disable iff (rst)
    in_valid && !in_stall |=> in_stall) else $error("second item taken");

endmodule

bind property_slot_hash_table pst_checker u_pst_checker (
  .clk           (clk),
  .rst           (rst),
  .in_valid      (in_valid),
  .in_stall      (in_stall),
  .out_valid     (out_valid),
  .out_stall     (out_stall),
  .status        (status),
  .invalidate    (invalidate),
  .live_count    (live_count),
  .deleted_total (deleted_total)
);

/* tb/sv/property_slot_hash_table_tb.sv */
// Self-checking testbench for property_slot_hash_table: a directed table, then random phases.
// Depends on pst_pkg and the property_slot_hash_table RTL; it has its own model of the slot table.
`timescale 1ns / 100ps

module property_slot_hash_table_tb;
  import pst_pkg::*;

  localparam int PERIOD = 12;

  typedef struct {
    status_t      status;
    logic [5:0]   slot;
    logic         inval;
    logic [6:0]   live;
    logic [6:0]   dels;
    logic         cmp;
    logic [61:0]  kid;
    logic         ksym;
    logic [7:0]   attr;
    bit           typed;
    status_t      t_status;
    logic [5:0]   t_slot;
  } slot_result_t;

  typedef struct {
    logic [2:0]  op;
    logic [61:0] id;
    logic        sym;
    logic [7:0]  attr;
    logic [5:0]  sin;
    bit          typed;
    status_t     t_status;
    logic [5:0]  t_slot;
  } dir_row_t;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic in_valid = 1'b0, in_stall;
  logic [2:0] op = '0;
  logic [ID_W-1:0] key_id = '0;
  logic key_is_symbol = 1'b0;
  logic [7:0] attrs = '0;
  logic [5:0] slot_in = '0;
  logic out_valid, out_stall = 1'b0;
  logic [1:0] status;
  logic [5:0] slot_out;
  logic invalidate, should_compact, key_is_symbol_out;
  logic [6:0] live_count, deleted_total;
  logic [ID_W-1:0] key_id_out;
  logic [7:0] attrs_out;
  logic cfg_valid = 1'b0, cfg_ready;
  logic [6:0] cfg_data = '0;

  // shadow copy of the slot table
  logic [KEY_W-1:0] shadow_key [NUM_SLOTS];
  logic [7:0]       shadow_attr[NUM_SLOTS];
  bit               shadow_del [NUM_SLOTS];
  int unsigned      shadow_cnt, shadow_dcnt, shadow_min;

  slot_result_t pending_results[$];
  dir_row_t     dir_tab[$];
  logic [61:0]  id_pool[48];
  bit           cur_typed;
  status_t      cur_t_status;
  logic [5:0]   cur_t_slot;
  bit           hold_req = 0, no_idle = 0;
  int           errors = 0, checked = 0, full_hits = 0, trims = 0;

  always #(PERIOD / 2) clk = ~clk;

  property_slot_hash_table u_top (
    .clk, .rst, .in_valid, .in_stall, .op, .key_id, .key_is_symbol, .attrs, .slot_in,
    .out_valid, .out_stall, .status, .slot_out, .invalidate, .live_count, .deleted_total,
    .should_compact, .key_id_out, .key_is_symbol_out, .attrs_out,
    .cfg_valid, .cfg_ready, .cfg_data
  );

  // Apply one operation to the shadow table and return the result it produces.
  function automatic slot_result_t apply_slot_op(logic [2:0] o, logic [61:0] id, logic sym,
                                                 logic [7:0] a, logic [5:0] sin);
    slot_result_t r;
    logic [KEY_W-1:0] k;
    int hit, dst;
    r = '{status: ST_OK, t_status: ST_OK, default: '0};
    k = {id, sym};
    hit = -1;
    if (o <= OP_SETATTR && k == '0) begin
      r.status = ST_NOKEY;
    end else if (o <= OP_SETATTR) begin
      for (int s = 0; s < shadow_cnt; s++)
        if (!shadow_del[s] && shadow_key[s] == k) hit = s;
      if (hit >= 0) begin
        if (o == OP_ADD && shadow_attr[hit] != a) begin
          shadow_attr[hit] = a;
          r.inval = 1'b1;
        end else if (o == OP_SETATTR) begin
          shadow_attr[hit] = a;
          r.inval = 1'b1;
        end
        r.slot = hit[5:0];
        r.attr = shadow_attr[hit];
      end else if (o != OP_ADD) begin
        r.status = ST_NOKEY;
      end else if (shadow_cnt >= NUM_SLOTS) begin
        r.status = ST_FULL;
        full_hits++;
      end else begin
        shadow_key[shadow_cnt] = k;
        shadow_attr[shadow_cnt] = a;
        shadow_del[shadow_cnt] = 0;
        r.slot = shadow_cnt[5:0];
        r.attr = a;
        shadow_cnt++;
      end
    end else if (o == OP_REMOVE || o == OP_READ) begin
      if (sin >= shadow_cnt || shadow_del[sin]) begin
        r.status = ST_BAD;
      end else if (o == OP_READ) begin
        r.kid = shadow_key[sin][KEY_W-1:1];
        r.ksym = shadow_key[sin][0];
        r.attr = shadow_attr[sin];
      end else begin
        shadow_del[sin] = 1;
        shadow_dcnt++;
        if (shadow_del[shadow_cnt-1]) trims++;
        // drop trailing deleted slots
        while (shadow_cnt > 0 && shadow_del[shadow_cnt-1]) begin
          shadow_cnt--;
          shadow_dcnt--;
        end
        r.inval = 1'b1;
      end
    end else if (o == OP_COMPACT && shadow_dcnt != 0) begin
      dst = 0;
      for (int s = 0; s < shadow_cnt; s++) begin
        if (shadow_del[s]) continue;
        shadow_key[dst] = shadow_key[s];
        shadow_attr[dst] = shadow_attr[s];
        shadow_del[dst] = 0;
        dst++;
      end
      for (int s = dst; s < shadow_cnt; s++) shadow_del[s] = 0;
      shadow_cnt = dst;
      shadow_dcnt = 0;
    end
    r.live = shadow_cnt[6:0];
    r.dels = shadow_dcnt[6:0];
    r.cmp = (shadow_dcnt >= shadow_min) && (shadow_dcnt >= shadow_cnt - shadow_dcnt);
    return r;
  endfunction

  // Predict on each input transfer, compare on each output transfer.
  always @(posedge clk) begin
    slot_result_t e, p;
    if (!rst && out_valid && !out_stall) begin
      if (pending_results.size() == 0) begin
        $display("%0t: unexpected result, status %0d slot %0d", $time, status, slot_out);
        errors++;
      end else begin
        e = pending_results.pop_front();
        checked++;
        if (status !== e.status || slot_out !== e.slot || invalidate !== e.inval ||
            live_count !== e.live || deleted_total !== e.dels || should_compact !== e.cmp ||
            key_id_out !== e.kid || key_is_symbol_out !== e.ksym || attrs_out !== e.attr) begin
          $display("%0t: mismatch exp st=%0d sl=%0d inv=%0d live=%0d del=%0d sc=%0d id=%h sym=%0d at=%h",
                   $time, e.status, e.slot, e.inval, e.live, e.dels, e.cmp, e.kid, e.ksym, e.attr);
          $display("%0t:          got st=%0d sl=%0d inv=%0d live=%0d del=%0d sc=%0d id=%h sym=%0d at=%h",
                   $time, status, slot_out, invalidate, live_count, deleted_total,
                   should_compact, key_id_out, key_is_symbol_out, attrs_out);
          errors++;
        end
        if (e.typed && (status !== e.t_status || slot_out !== e.t_slot)) begin
          $display("%0t: table row expected status %0d slot %0d, got status %0d slot %0d",
                   $time, e.t_status, e.t_slot, status, slot_out);
          errors++;
        end
      end
    end
    if (!rst && in_valid && !in_stall) begin
      p = apply_slot_op(op, key_id, key_is_symbol, attrs, slot_in);
      p.typed = cur_typed;
      p.t_status = cur_t_status;
      p.t_slot = cur_t_slot;
      pending_results.push_back(p);
    end
  end

  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (no_idle || r < 65) return 0;
    if (r < 97) return $urandom_range(1, 3);
    return $urandom_range(15, 60);
  endfunction

  // Receiver: random stall, with one long hold-off on request.
  initial begin
    int n;
    forever begin
      @(negedge clk);
      if (hold_req) begin
        out_stall = 1'b1;
        repeat (300) @(negedge clk);
        hold_req = 0;
      end
      n = pick_gap();
      if (n == 0) begin
        out_stall = 1'b0;
      end else begin
        out_stall = 1'b1;
        repeat (n - 1) @(negedge clk);
      end
    end
  end

  // Offer one item and hold it until the transfer.
  task automatic send_item(logic [2:0] o, logic [61:0] id, logic sym, logic [7:0] a,
                           logic [5:0] sin, bit typed = 0, status_t ts = ST_OK,
                           logic [5:0] tsl = '0);
    int gap;
    gap = pick_gap();
    if (gap > 0) begin
      @(negedge clk);
      in_valid = 1'b0;
      repeat (gap - 1) @(negedge clk);
    end
    @(negedge clk);
    op = o;
    key_id = id;
    key_is_symbol = sym;
    attrs = a;
    slot_in = sin;
    cur_typed = typed;
    cur_t_status = ts;
    cur_t_slot = tsl;
    in_valid = 1'b1;
    @(posedge clk);
    while (in_stall) @(posedge clk);
  endtask

  task automatic drain();
    @(negedge clk);
    in_valid = 1'b0;
    wait (pending_results.size() == 0);
    repeat (150) @(negedge clk);
  endtask

  task automatic write_min_deleted(logic [6:0] v);
    @(negedge clk);
    cfg_data = v;
    cfg_valid = 1'b1;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    shadow_min = v;
    @(negedge clk);
    cfg_valid = 1'b0;
  endtask

  task automatic add_row(logic [2:0] o, logic [61:0] id, logic sym, logic [7:0] a,
                         logic [5:0] sin, bit typed = 0, status_t ts = ST_OK,
                         logic [5:0] tsl = '0);
    dir_tab.push_back('{o, id, sym, a, sin, typed, ts, tsl});
  endtask

  function automatic logic [61:0] rand_id();
    logic [63:0] v;
    v = {$urandom, $urandom};
    return v[61:0];
  endfunction

  // Random item: mostly known keys so hits, removes and compaction happen.
  task automatic send_random();
    int r;
    logic [2:0] o;
    logic [61:0] id;
    r = $urandom_range(0, 99);
    if (r < 35) o = OP_ADD;
    else if (r < 50) o = OP_LOOKUP;
    else if (r < 60) o = OP_SETATTR;
    else if (r < 80) o = OP_REMOVE;
    else if (r < 85) o = OP_COMPACT;
    else if (r < 97) o = OP_READ;
    else o = 3'($urandom_range(6, 7));
    r = $urandom_range(0, 99);
    id = (r < 85) ? id_pool[$urandom_range(0, 47)] : (r < 98) ? rand_id() : '0;
    send_item(o, id, (r < 98) ? 1'($urandom) : 1'b0, 8'($urandom),
              (shadow_cnt > 0 && $urandom_range(0, 9) < 8) ?
                6'($urandom_range(0, shadow_cnt - 1)) : 6'($urandom));
  endtask

  initial begin
    logic [6:0] cfg_vals[5];
    for (int s = 0; s < NUM_SLOTS; s++) shadow_del[s] = 0;
    shadow_cnt = 0;
    shadow_dcnt = 0;
    shadow_min = CMP_MIN_RESET;
    for (int i = 0; i < 48; i++) id_pool[i] = (i < 6) ? 62'(i + 1) : rand_id();
    cfg_vals = '{7'd0, 7'd64, 7'd1, 7'd20, 7'($urandom_range(0, 64))};
    repeat (9) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    // directed table
    add_row(OP_READ, 0, 0, 0, 0, 1, ST_BAD, 0);
    add_row(OP_REMOVE, 0, 0, 0, 0, 1, ST_BAD, 0);
    add_row(OP_LOOKUP, 0, 0, 0, 0, 1, ST_NOKEY, 0);
    add_row(OP_ADD, 0, 0, 8'h5a, 0, 1, ST_NOKEY, 0);
    add_row(OP_SETATTR, 0, 0, 8'h5a, 0, 1, ST_NOKEY, 0);
    add_row(OP_ADD, {62{1'b1}}, 1, 8'hff, 0, 1, ST_OK, 0);
    add_row(OP_ADD, 1, 0, 8'h00, 0, 1, ST_OK, 1);
    add_row(OP_ADD, 0, 1, 8'h81, 0, 1, ST_OK, 2);
    add_row(OP_ADD, {62{1'b1}}, 1, 8'hff, 0, 1, ST_OK, 0);
    add_row(OP_ADD, {62{1'b1}}, 1, 8'h00, 0);
    add_row(OP_LOOKUP, 5, 0, 0, 0, 1, ST_NOKEY, 0);
    add_row(OP_SETATTR, 1, 0, 8'haa, 0);
    add_row(OP_LOOKUP, 1, 0, 0, 0);
    add_row(OP_READ, 0, 0, 0, 6'd0);
    add_row(OP_READ, 0, 0, 0, 6'd63, 1, ST_BAD, 0);
    add_row(OP_COMPACT, 0, 0, 0, 0, 1, ST_OK, 0);
    add_row(OP_REMOVE, 0, 0, 0, 6'd0, 1, ST_OK, 0);
    add_row(OP_READ, 0, 0, 0, 6'd0, 1, ST_BAD, 0);
    add_row(OP_REMOVE, 0, 0, 0, 6'd0, 1, ST_BAD, 0);
    add_row(OP_COMPACT, 0, 0, 0, 0);
    add_row(3'd6, 7, 1, 8'h11, 6'd3, 1, ST_OK, 0);
    add_row(3'd7, 7, 1, 8'h11, 6'd3, 1, ST_OK, 0);
    add_row(OP_REMOVE, 0, 0, 0, 6'd0);
    add_row(OP_REMOVE, 0, 0, 0, 6'd1);
    add_row(OP_READ, 0, 0, 0, 6'd0, 1, ST_BAD, 0);
    foreach (dir_tab[i])
      send_item(dir_tab[i].op, dir_tab[i].id, dir_tab[i].sym, dir_tab[i].attr,
                dir_tab[i].sin, dir_tab[i].typed, dir_tab[i].t_status, dir_tab[i].t_slot);
    drain();

    // random phases, each under its own threshold
    for (int ph = 0; ph < 5; ph++) begin
      write_min_deleted(cfg_vals[ph]);
      hold_req = (ph == 1);
      no_idle = (ph == 2);
      if (ph == 3) begin
        // fill the table past its capacity, then punch holes
        for (int i = 0; i < 70; i++)
          send_item(OP_ADD, rand_id(), 1'($urandom), 8'($urandom), 0);
        for (int i = 0; i < 40; i++) send_item(OP_REMOVE, 0, 0, 0, 6'($urandom));
      end
      for (int i = 0; i < 140; i++) send_random();
      drain();
    end
    no_idle = 0;

    $display("covered %0d results over five threshold settings;", checked);
    $display("%0d adds hit a full table, %0d removes trimmed", full_hits, trims);
    if (errors == 0 && pending_results.size() == 0) begin
      $display("property_slot_hash_table_tb: done, clean");
    end else begin
      $display("property_slot_hash_table_tb: done, errors");
    end
    $finish;
  end

  // Give up after a generous bound.
  initial begin
    #40000000;
    $display("property_slot_hash_table_tb: done, errors");
    $finish;
  end

endmodule
